// ===== rtl/core/mcl_pkg.sv =====
`default_nettype none
package mcl_pkg;

  localparam int LINES  = 1024;
  localparam int LINE_W = $clog2(LINES);
  localparam int FUNC_W = 3;
  localparam int ST_W   = 3;
  localparam int ADDR_W = 32;
  localparam int SRC_W  = 4;
  localparam int REQ_W  = 2;

  // item function codes
  localparam logic [FUNC_W-1:0] FN_LOAD  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_STORE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_GETS  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_GETM  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DATA  = 3'd4;

  // line coherence states
  localparam logic [ST_W-1:0] LS_I  = 3'd0;
  localparam logic [ST_W-1:0] LS_S  = 3'd1;
  localparam logic [ST_W-1:0] LS_E  = 3'd2;
  localparam logic [ST_W-1:0] LS_M  = 3'd3;
  localparam logic [ST_W-1:0] LS_IM = 3'd4;
  localparam logic [ST_W-1:0] LS_IS = 3'd5;
  localparam logic [ST_W-1:0] LS_SM = 3'd6;

  // bus requests
  localparam logic [REQ_W-1:0] REQ_NONE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_GETS = 2'd1;
  localparam logic [REQ_W-1:0] REQ_GETM = 2'd2;

  typedef enum logic [1:0] {
    CTL_CLEAR,
    CTL_IDLE,
    CTL_LOOKUP
  } ctl_state_t;

  typedef struct packed {
    logic [REQ_W-1:0]  bus_request;
    logic              data_to_proc;
    logic              data_on_bus;
    logic [SRC_W-1:0]  data_dest;
    logic              shared_out;
    logic              miss;
    logic              silent_upgrade;
    logic              error;
    logic [ST_W-1:0]   new_state;
    logic [ADDR_W-1:0] addr_out;
  } rsp_t;

  function automatic rsp_t mcl_step(logic [FUNC_W-1:0] func, logic [ST_W-1:0] st_raw,
                                    logic shin, logic [SRC_W-1:0] src,
                                    logic [ADDR_W-1:0] addr);
    rsp_t r;
    logic [ST_W-1:0] st;
    logic store;
    logic getm;
    r     = '0;
    st    = (st_raw > LS_SM) ? LS_I : st_raw;
    store = (func == FN_STORE);
    getm  = (func == FN_GETM);
    r.new_state = st;
    if (func == FN_LOAD || func == FN_STORE) begin
      case (st)
        LS_I: begin
          r.bus_request = store ? REQ_GETM : REQ_GETS;
          r.new_state   = store ? LS_IM : LS_IS;
          r.miss        = 1'b1;
        end
        LS_S: begin
          if (store) begin
            r.bus_request = REQ_GETM;
            r.new_state   = LS_SM;
            r.miss        = 1'b1;
          end else begin
            r.data_to_proc = 1'b1;
          end
        end
        LS_E: begin
          r.data_to_proc = 1'b1;
          if (store) begin
            r.silent_upgrade = 1'b1;
            r.new_state      = LS_M;
          end
        end
        LS_M: r.data_to_proc = 1'b1;
        default: r.error = 1'b1;
      endcase
    end else if (func == FN_GETS || func == FN_GETM) begin
      case (st)
        LS_S: begin
          r.shared_out = 1'b1;
          if (getm) r.new_state = LS_I;
        end
        LS_E, LS_M: begin
          r.shared_out  = 1'b1;
          r.data_on_bus = 1'b1;
          r.data_dest   = src;
          r.new_state   = getm ? LS_I : LS_S;
        end
        LS_SM: r.shared_out = 1'b1;
        default: ;
      endcase
    end else if (func == FN_DATA) begin
      case (st)
        LS_IM, LS_SM: begin
          r.data_to_proc = 1'b1;
          r.new_state    = LS_M;
        end
        LS_IS: begin
          r.data_to_proc = 1'b1;
          r.new_state    = shin ? LS_S : LS_E;
        end
        default: ;
      endcase
    end else begin
      r.error = 1'b1;
    end
    if (r.bus_request != REQ_NONE || r.data_to_proc || r.data_on_bus) begin
      r.addr_out = addr;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mcl_if.sv =====
`default_nettype none
interface mcl_item_if;
  logic                          valid;
  logic                          ready;
  logic [mcl_pkg::FUNC_W-1:0]    func;
  logic [9:0]                    line;
  logic [mcl_pkg::ADDR_W-1:0]    addr;
  logic [mcl_pkg::SRC_W-1:0]     src_module;
  logic                          shared_in;

  modport source (output valid, func, line, addr, src_module, shared_in, input ready);
  modport sink (input valid, func, line, addr, src_module, shared_in, output ready);
endinterface

interface mcl_result_if;
  logic                          valid;
  logic                          ready;
  logic [mcl_pkg::REQ_W-1:0]     bus_request;
  logic                          data_to_proc;
  logic                          data_on_bus;
  logic [mcl_pkg::SRC_W-1:0]     data_dest;
  logic                          shared_out;
  logic                          miss;
  logic                          silent_upgrade;
  logic                          error;
  logic [mcl_pkg::ST_W-1:0]      new_state;
  logic [mcl_pkg::ADDR_W-1:0]    addr_out;

  modport source (output valid, bus_request, data_to_proc, data_on_bus, data_dest,
                  shared_out, miss, silent_upgrade, error, new_state, addr_out,
                  input ready);
  modport sink (input valid, bus_request, data_to_proc, data_on_bus, data_dest,
                shared_out, miss, silent_upgrade, error, new_state, addr_out,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mcl_ram.sv =====
`default_nettype none
module mcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/mesi_coherence_line_controller.sv =====
`default_nettype none
// result: computed from the line table read in LOOKUP and loaded into the output register once that register is free
// items: one at a time; the next is taken only after the line table read and write back
// the next item is taken while a finished result still waits in the output register
// reset: a clearing pass writes Invalid to all 1024 lines,
// during which no item is taken; the output register is emptied at once
module mesi_coherence_line_controller (
  input wire logic     clk,
  input wire logic     rst,
  mcl_item_if.sink     item,
  mcl_result_if.source result
);

  mcl_pkg::ctl_state_t ctl_state, ctl_state_next;

  logic [mcl_pkg::LINE_W-1:0] clr_idx;
  logic [mcl_pkg::LINE_W-1:0] line_q;
  logic [mcl_pkg::FUNC_W-1:0] func_q;
  logic [mcl_pkg::ADDR_W-1:0] addr_q;
  logic [mcl_pkg::SRC_W-1:0]  src_q;
  logic                       shin_q;

  logic                       ram_we;
  logic [mcl_pkg::LINE_W-1:0] ram_waddr;
  logic [mcl_pkg::ST_W-1:0]   ram_wdata;
  logic                       ram_re;
  logic [mcl_pkg::ST_W-1:0]   ram_rdata;

  logic          slot_free;
  logic          out_load;
  mcl_pkg::rsp_t rsp;

  assign slot_free = !result.valid || result.ready;
  assign rsp = mcl_pkg::mcl_step(func_q, ram_rdata, shin_q, src_q, addr_q);

  mcl_ram #(
    .WIDTH(mcl_pkg::ST_W),
    .DEPTH(mcl_pkg::LINES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(item.line[mcl_pkg::LINE_W-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    ctl_state_next = ctl_state;
    unique case (ctl_state)
      mcl_pkg::CTL_CLEAR: begin
        if (clr_idx == mcl_pkg::LINE_W'(mcl_pkg::LINES - 1)) ctl_state_next = mcl_pkg::CTL_IDLE;
      end
      mcl_pkg::CTL_IDLE: begin
        if (item.valid) ctl_state_next = mcl_pkg::CTL_LOOKUP;
      end
      mcl_pkg::CTL_LOOKUP: begin
        if (slot_free) ctl_state_next = mcl_pkg::CTL_IDLE;
      end
      default: ctl_state_next = mcl_pkg::CTL_CLEAR;
    endcase
  end

  always_comb begin
    item.ready = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = line_q;
    ram_wdata  = rsp.new_state;
    out_load   = 1'b0;
    unique case (ctl_state)
      mcl_pkg::CTL_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        ram_wdata = mcl_pkg::LS_I;
      end
      mcl_pkg::CTL_IDLE: begin
        item.ready = 1'b1;
        ram_re     = item.valid;
      end
      mcl_pkg::CTL_LOOKUP: begin
        // write back only when the result can go into the output register
        ram_we   = slot_free;
        out_load = slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_state <= mcl_pkg::CTL_CLEAR;
      clr_idx   <= '0;
    end else begin
      ctl_state <= ctl_state_next;
      if (ctl_state == mcl_pkg::CTL_CLEAR) clr_idx <= clr_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      line_q <= item.line[mcl_pkg::LINE_W-1:0];
      func_q <= item.func;
      addr_q <= item.addr;
      src_q  <= item.src_module;
      shin_q <= item.shared_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.bus_request    <= rsp.bus_request;
      result.data_to_proc   <= rsp.data_to_proc;
      result.data_on_bus    <= rsp.data_on_bus;
      result.data_dest      <= rsp.data_dest;
      result.shared_out     <= rsp.shared_out;
      result.miss           <= rsp.miss;
      result.silent_upgrade <= rsp.silent_upgrade;
      result.error          <= rsp.error;
      result.new_state      <= rsp.new_state;
      result.addr_out       <= rsp.addr_out;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mcl_chk.sv =====
`default_nettype none
module mcl_chk (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         item_valid,
  input wire logic                         item_ready,
  input wire logic                         result_valid,
  input wire logic                         result_ready,
  input wire logic [mcl_pkg::REQ_W-1:0]    result_bus_request,
  input wire logic                         result_data_to_proc,
  input wire logic                         result_data_on_bus,
  input wire logic [mcl_pkg::SRC_W-1:0]    result_data_dest,
  input wire logic                         result_miss,
  input wire logic                         result_error,
  input wire logic [mcl_pkg::ST_W-1:0]     result_new_state,
  input wire logic [mcl_pkg::ADDR_W-1:0]   result_addr_out
);

  // the clearing pass follows every reset
  a_clear_after_reset: assert property (@(posedge clk) $past(rst) |-> !item_ready)
    else $error("item taken during table clearing");

  // one item in the read-modify-write loop at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item taken while the previous one is in lookup");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_new_state)
      && $stable(result_error) && $stable(result_addr_out))
    else $error("stalled result changed");

  // an illegal item produces no traffic
  a_error_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_error |-> result_bus_request == mcl_pkg::REQ_NONE
      && !result_data_to_proc && !result_data_on_bus && result_addr_out == '0)
    else $error("error result carries traffic");

  a_miss_requests: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_miss |-> result_bus_request != mcl_pkg::REQ_NONE
      && !result_data_on_bus && result_data_dest == '0)
    else $error("miss without bus request");

endmodule

bind mesi_coherence_line_controller mcl_chk u_mcl_chk (
  .clk                (clk),
  .rst                (rst),
  .item_valid         (item.valid),
  .item_ready         (item.ready),
  .result_valid       (result.valid),
  .result_ready       (result.ready),
  .result_bus_request (result.bus_request),
  .result_data_to_proc(result.data_to_proc),
  .result_data_on_bus (result.data_on_bus),
  .result_data_dest   (result.data_dest),
  .result_miss        (result.miss),
  .result_error       (result.error),
  .result_new_state   (result.new_state),
  .result_addr_out    (result.addr_out)
);
`default_nettype wire
